>>> rtl/poam_pkg.sv
// Shared types and constants for the polygon area / orientation / mean block.
// Holds the input and result beat structs, the queue entry and the back-end states.
// Depends on nothing.
`timescale 1ns / 1ps

package poam_pkg;

    localparam int VTX_W            = 16;
    localparam int AREA_W           = 37;
    localparam int COUNT_W          = 7;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int FIFO_DEPTH_DEF   = 4;

    typedef struct packed {
        logic signed [VTX_W-1:0] vertex_x;
        logic signed [VTX_W-1:0] vertex_y;
        logic                    last_vertex;
    } t_vertex_in;

    typedef struct packed {
        logic [AREA_W-1:0]       area;
        logic                    clockwise;
        logic signed [VTX_W-1:0] mean_x;
        logic signed [VTX_W-1:0] mean_y;
        logic [COUNT_W-1:0]      count;
        logic                    overflowed;
    } t_result_out;

    typedef struct packed {
        logic signed [VTX_W-1:0] x;
        logic signed [VTX_W-1:0] y;
        logic                    keep;
        logic                    last;
        logic                    dropped;
    } t_vtx_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [2:0] {
        S_RUN,
        S_CLOSE,
        S_FOLD,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

>>> rtl/polygon_area_orientation_mean.sv
// Shoelace polygon area, orientation and mean: one vertex beat per cycle into the queue unless it is full.
// Back end retires one vertex per cycle while in its run state; a polygon close then steps through the
// close, fold, divide and done states, the divide state using a bit-serial mean divider of width
// SUM_W = 16 + clog2(MAX_VERTICES + 1); the done state loads the result beat once the output is free.
// Synchronous active-low reset clears all accumulators, the queue and the result valid flag.
`timescale 1ns / 1ps

module polygon_area_orientation_mean #(
    parameter int MAX_VERTICES = poam_pkg::MAX_VERTICES_DEF,
    parameter int FIFO_DEPTH   = poam_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  poam_pkg::t_vertex_in  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output poam_pkg::t_result_out o_out
);
    import poam_pkg::*;

    logic       w_push;
    logic       w_pop;
    t_vtx_cmd   w_cmd;
    t_vtx_cmd   w_head;
    t_fifo_stat w_stat;

    poam_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_fifo_stat (w_stat),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    poam_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    poam_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_fifo_stat (w_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("queue pop while empty");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

endmodule

>>> rtl/poam_front.sv
// Front end: accepts vertex beats, tracks capacity and classifies each vertex.
// Pushes kept vertices and polygon closes into the command queue.
// Depends on poam_pkg.
`timescale 1ns / 1ps

module poam_front #(
    parameter int MAX_VERTICES = poam_pkg::MAX_VERTICES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  poam_pkg::t_vertex_in i_in,
    input  poam_pkg::t_fifo_stat i_fifo_stat,
    output logic                 o_push,
    output poam_pkg::t_vtx_cmd   o_cmd
);
    import poam_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] n_total;
    logic             r_drop;
    logic             n_drop;
    logic             w_accept;
    logic             w_full;

    assign o_in_stall = i_fifo_stat.full;
    assign w_accept   = i_in_valid && !i_fifo_stat.full;
    assign w_full     = (r_total == CNT_W'(MAX_VERTICES));

    assign o_cmd.x       = i_in.vertex_x;
    assign o_cmd.y       = i_in.vertex_y;
    assign o_cmd.keep    = !w_full;
    assign o_cmd.last    = i_in.last_vertex;
    assign o_cmd.dropped = r_drop || w_full;
    assign o_push        = w_accept && (!w_full || i_in.last_vertex);

    always_comb begin
        n_total = r_total;
        n_drop  = r_drop;
        if (w_accept) begin
            if (i_in.last_vertex) begin
                n_total = '0;
                n_drop  = 1'b0;
            end else begin
                if (!w_full) begin
                    n_total = r_total + CNT_W'(1);
                end
                n_drop = r_drop || w_full;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_total <= n_total;
            r_drop  <= n_drop;
        end
    end

endmodule

>>> rtl/poam_fifo.sv
// Short command queue between the front end and the back end.
// Register array with head/tail pointers and an occupancy count.
// Depends on poam_pkg.
`timescale 1ns / 1ps

module poam_fifo #(
    parameter int DEPTH = poam_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  poam_pkg::t_vtx_cmd   i_cmd,
    input  logic                 i_pop,
    output poam_pkg::t_vtx_cmd   o_head,
    output poam_pkg::t_fifo_stat o_stat
);
    import poam_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    t_vtx_cmd         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_occ == OCC_W'(DEPTH));
    assign o_stat.empty = (r_occ == '0);

    always_comb begin
        n_occ = r_occ;
        if (i_push && !i_pop) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (!i_push && i_pop) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            r_occ <= n_occ;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

>>> rtl/poam_div.sv
// Restoring divider: signed sum over unsigned vertex count, truncated toward zero.
// One quotient bit per cycle over the magnitude, sign applied at the output.
// Depends on poam_pkg.
`timescale 1ns / 1ps

module poam_div #(
    parameter int SUM_W = poam_pkg::VTX_W + poam_pkg::COUNT_W,
    parameter int CNT_W = poam_pkg::COUNT_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quot
);
    import poam_pkg::*;

    localparam int IT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic [SUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_rem;
    logic [IT_W-1:0]  r_iter;
    logic             r_busy;
    logic             r_neg;
    logic             r_done;
    logic [CNT_W:0]   w_rem_sh;
    logic [CNT_W:0]   w_rem_sub;
    logic             w_ge;

    assign w_rem_sh  = {r_rem, r_q[SUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, i_divisor});
    assign w_rem_sub = w_rem_sh - {1'b0, i_divisor};
    assign o_done    = r_done;
    assign o_quot    = r_neg ? $signed(~r_q + SUM_W'(1)) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
            r_rem <= '0;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + IT_W'(1);
                if (r_iter == IT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/poam_back.sv
// Back end: pops vertex commands, accumulates shoelace cross products and sums,
// closes the polygon, divides for the mean and holds the result beat.
// Depends on poam_pkg and poam_div.
`timescale 1ns / 1ps

module poam_back #(
    parameter int MAX_VERTICES = poam_pkg::MAX_VERTICES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  poam_pkg::t_vtx_cmd    i_head,
    input  poam_pkg::t_fifo_stat  i_fifo_stat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output poam_pkg::t_result_out o_out
);
    import poam_pkg::*;

    localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W    = VTX_W + CNT_W;
    localparam int CROSS_N  = 2 * VTX_W + 2 + $clog2(MAX_VERTICES);
    localparam int CROSS_W  = (CROSS_N > AREA_W + 2) ? CROSS_N : AREA_W + 2;
    localparam int PROD_W   = 2 * VTX_W;

    t_back_state r_state;
    t_back_state n_state;

    logic signed [VTX_W-1:0]   r_first_x;
    logic signed [VTX_W-1:0]   r_first_y;
    logic signed [VTX_W-1:0]   r_prev_x;
    logic signed [VTX_W-1:0]   r_prev_y;
    logic signed [CROSS_W-1:0] r_cross;
    logic signed [SUM_W-1:0]   r_sum_x;
    logic signed [SUM_W-1:0]   r_sum_y;
    logic [CNT_W-1:0]          r_count;
    logic                      r_drop;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic                      r_prod_vld;
    logic                      r_out_vld;
    t_result_out               r_out;

    logic                      w_pop;
    logic                      w_close;
    logic                      w_div_start;
    logic                      w_load;
    logic signed [VTX_W-1:0]   w_bx;
    logic signed [VTX_W-1:0]   w_by;
    logic signed [PROD_W-1:0]  w_p1;
    logic signed [PROD_W-1:0]  w_p2;
    logic [CROSS_W-1:0]        w_mag;
    logic                      w_sat;
    logic                      w_done_x;
    logic                      w_done_y;
    logic signed [SUM_W-1:0]   w_quot_x;
    logic signed [SUM_W-1:0]   w_quot_y;
    t_result_out               w_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (!i_fifo_stat.empty && i_head.last) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: n_state = S_FOLD;
            S_FOLD:  n_state = S_DIV;
            S_DIV: begin
                if (w_done_x && w_done_y) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        w_pop       = 1'b0;
        w_close     = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            S_RUN:   w_pop       = !i_fifo_stat.empty;
            S_CLOSE: w_close     = 1'b1;
            S_FOLD:  w_div_start = 1'b1;
            S_DIV:   w_pop       = 1'b0;
            S_DONE:  w_load      = !r_out_vld || !i_out_stall;
            default: w_pop       = 1'b0;
        endcase
    end

    assign o_pop = w_pop;

    // edge from previous vertex to head vertex, or closing edge back to the first
    assign w_bx = w_close ? r_first_x : i_head.x;
    assign w_by = w_close ? r_first_y : i_head.y;
    assign w_p1 = r_prev_x * w_by;
    assign w_p2 = w_bx * r_prev_y;

    poam_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum_x),
        .i_divisor  (r_count),
        .o_done     (w_done_x),
        .o_quot     (w_quot_x)
    );

    poam_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum_y),
        .i_divisor  (r_count),
        .o_done     (w_done_y),
        .o_quot     (w_quot_y)
    );

    assign w_mag = r_cross[CROSS_W-1] ? (~r_cross + CROSS_W'(1)) : r_cross;
    assign w_sat = |w_mag[CROSS_W-1:AREA_W+1];

    always_comb begin
        w_res.area       = w_sat ? {AREA_W{1'b1}} : w_mag[AREA_W:1];
        w_res.clockwise  = r_cross[CROSS_W-1];
        w_res.mean_x     = (r_count == '0) ? '0 : w_quot_x[VTX_W-1:0];
        w_res.mean_y     = (r_count == '0) ? '0 : w_quot_y[VTX_W-1:0];
        w_res.count      = COUNT_W'(r_count);
        w_res.overflowed = r_drop;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        r_p1 <= w_p1;
        r_p2 <= w_p2;
        if (w_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_cross    <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_count    <= '0;
            r_drop     <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prod_vld <= (w_pop && i_head.keep && (r_count != '0)) || w_close;
            if (r_prod_vld) begin
                r_cross <= r_cross + CROSS_W'(r_p1) - CROSS_W'(r_p2);
            end
            if (w_pop) begin
                r_drop <= r_drop || i_head.dropped;
                if (i_head.keep) begin
                    if (r_count == '0) begin
                        r_first_x <= i_head.x;
                        r_first_y <= i_head.y;
                    end
                    r_prev_x <= i_head.x;
                    r_prev_y <= i_head.y;
                    r_sum_x  <= r_sum_x + {{(SUM_W-VTX_W){i_head.x[VTX_W-1]}}, i_head.x};
                    r_sum_y  <= r_sum_y + {{(SUM_W-VTX_W){i_head.y[VTX_W-1]}}, i_head.y};
                    r_count  <= r_count + CNT_W'(1);
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
                r_first_x <= '0;
                r_first_y <= '0;
                r_prev_x  <= '0;
                r_prev_y  <= '0;
                r_cross   <= '0;
                r_sum_x   <= '0;
                r_sum_y   <= '0;
                r_count   <= '0;
                r_drop    <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule
